FILE: rtl/core/kmms_pkg.sv
`default_nettype none
package kmms_pkg;

  localparam int WAYS      = 8;
  localparam int RUN_DEPTH = 1024;

  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int PTR_W     = $clog2(RUN_DEPTH);
  localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
  localparam int ADDR_W    = WAY_W + PTR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic        we;
    logic        re;
    addr_t       addr;
    logic [31:0] wdata;
  } mem_req_t;

  function automatic ptr_t ptr_advance(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(RUN_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/kway_merge_min_select_top.sv
`default_nettype none
// K-way merge engine: per-way FIFOs of sorted signed 32-bit runs, min-select take.
// Request channel: drive func_i, way_i, value_i and raise start; the request is
// taken at a rising edge where start is high and busy is low.
// Load (func_i = 0): appends value_i to way way_i in the accept cycle; busy stays
// low, so loads go at one per cycle. A load into a full way or to a way number
// at or above WAYS is dropped and gives no result.
// Take (func_i = 1): busy rises while the heads are read from the shared run
// memory one way per cycle and fed to a single signed comparator; ties keep the
// lower way. The scan runs through ST_SCAN, then ST_LAST and ST_UPDATE; the result
// is registered from ST_UPDATE and appears on out_value_o, out_way_o, status_o and
// all_drained_o for one cycle with valid_o high; busy is low again in that same
// cycle. The one-way-per-cycle head scan sets the length of a take.
// A take with every way empty returns status_o = 1, all_drained_o = 1 and zeros.
// The receiver cannot stall: each result must be captured in its valid_o cycle.
// Reset empties every way at once (pointers and counts clear); the run memory
// itself is not cleared and needs no clearing pass.
module kway_merge_min_select_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire         func_i,
  input  wire  [2:0]  way_i,
  input  wire  [31:0] value_i,
  output logic        valid_o,
  output logic [31:0] out_value_o,
  output logic [2:0]  out_way_o,
  output logic        status_o,
  output logic        all_drained_o
);

  kmms_pkg::state_e state_q, state_d;

  kmms_pkg::way_t  idx_q;
  logic            pend_q;
  kmms_pkg::way_t  pend_way_q;
  logic            found_q;
  kmms_pkg::way_t  best_way_q;
  logic [31:0]     best_val_q;

  kmms_pkg::ptr_t  head_q [kmms_pkg::WAYS];
  kmms_pkg::ptr_t  tail_q [kmms_pkg::WAYS];
  kmms_pkg::cnt_t  fill_q [kmms_pkg::WAYS];
  logic [kmms_pkg::WAYS-1:0] ne_q;
  logic [kmms_pkg::WAYS-1:0] ne_after;

  logic            valid_q;
  logic [31:0]     out_value_q;
  logic [2:0]      out_way_q;
  logic            status_q;
  logic            drained_q;

  kmms_pkg::way_t  sel_way;
  kmms_pkg::ptr_t  sel_head;
  kmms_pkg::ptr_t  sel_tail;
  kmms_pkg::cnt_t  sel_fill;
  logic            accept;
  logic            load_ok;
  logic            take_go;
  logic            better;
  logic            pop;
  logic [31:0]     rdata;
  kmms_pkg::mem_req_t mem_req;

  assign accept  = start && (state_q == kmms_pkg::ST_IDLE);
  assign busy    = (state_q != kmms_pkg::ST_IDLE);
  assign take_go = accept && (func_i == kmms_pkg::FUNC_TAKE);

  always_comb begin
    case (state_q)
      kmms_pkg::ST_IDLE: sel_way = kmms_pkg::way_t'(way_i);
      kmms_pkg::ST_SCAN: sel_way = idx_q;
      default:           sel_way = best_way_q;
    endcase
  end

  assign sel_head = head_q[sel_way];
  assign sel_tail = tail_q[sel_way];
  assign sel_fill = fill_q[sel_way];

  assign load_ok = accept && (func_i == kmms_pkg::FUNC_LOAD)
                   && (int'(way_i) < kmms_pkg::WAYS)
                   && (sel_fill != kmms_pkg::cnt_t'(kmms_pkg::RUN_DEPTH));

  assign pop = (state_q == kmms_pkg::ST_UPDATE) && found_q;

  always_comb begin
    mem_req.we    = load_ok;
    mem_req.re    = (state_q == kmms_pkg::ST_SCAN);
    mem_req.addr  = {sel_way, (state_q == kmms_pkg::ST_SCAN) ? sel_head : sel_tail};
    mem_req.wdata = value_i;
  end

  kmms_run_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign better = pend_q && (!found_q || ($signed(rdata) < $signed(best_val_q)));

  always_comb begin
    ne_after = ne_q;
    if (found_q) begin
      ne_after[best_way_q] = (sel_fill != kmms_pkg::cnt_t'(1));
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kmms_pkg::ST_IDLE: begin
        if (take_go) begin
          state_d = kmms_pkg::ST_SCAN;
        end
      end
      kmms_pkg::ST_SCAN: begin
        if (idx_q == kmms_pkg::way_t'(kmms_pkg::WAYS - 1)) begin
          state_d = kmms_pkg::ST_LAST;
        end
      end
      kmms_pkg::ST_LAST:   state_d = kmms_pkg::ST_UPDATE;
      kmms_pkg::ST_UPDATE: state_d = kmms_pkg::ST_IDLE;
      default:             state_d = kmms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmms_pkg::ST_IDLE;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == kmms_pkg::ST_UPDATE);
      if (take_go) begin
        found_q <= 1'b0;
      end else if (better) begin
        found_q <= 1'b1;
      end
      pend_q <= (state_q == kmms_pkg::ST_SCAN) && (sel_fill != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_go) begin
      idx_q <= '0;
    end else if (state_q == kmms_pkg::ST_SCAN) begin
      idx_q <= idx_q + kmms_pkg::way_t'(1);
    end
    pend_way_q <= idx_q;
    if (better) begin
      best_way_q <= pend_way_q;
      best_val_q <= rdata;
    end
    if (state_q == kmms_pkg::ST_UPDATE) begin
      out_value_q <= found_q ? best_val_q : 32'd0;
      out_way_q   <= found_q ? 3'(best_way_q) : 3'd0;
      status_q    <= found_q ? kmms_pkg::STATUS_OK : kmms_pkg::STATUS_EMPTY;
      drained_q   <= ~|ne_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kmms_pkg::WAYS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
      ne_q <= '0;
    end else begin
      if (load_ok) begin
        tail_q[sel_way] <= kmms_pkg::ptr_advance(sel_tail);
        fill_q[sel_way] <= sel_fill + kmms_pkg::cnt_t'(1);
        ne_q[sel_way]   <= 1'b1;
      end
      if (pop) begin
        head_q[sel_way] <= kmms_pkg::ptr_advance(sel_head);
        fill_q[sel_way] <= sel_fill - kmms_pkg::cnt_t'(1);
        ne_q[sel_way]   <= (sel_fill != kmms_pkg::cnt_t'(1));
      end
    end
  end

  assign valid_o       = valid_q;
  assign out_value_o   = out_value_q;
  assign out_way_o     = out_way_q;
  assign status_o      = status_q;
  assign all_drained_o = drained_q;

  a_take_holds_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_go |=> busy)
    else $error("take did not raise busy");

  a_result_ends_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy && $past(state_q == kmms_pkg::ST_UPDATE))
    else $error("result not at end of take");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> (all_drained_o && out_value_o == 32'd0 && out_way_o == 3'd0))
    else $error("empty result carries data");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !mem_req.we)
    else $error("memory write during take");

endmodule
`default_nettype wire

FILE: rtl/core/kmms_run_mem.sv
`default_nettype none
module kmms_run_mem (
  input  wire                 clk_i,
  input  wire kmms_pkg::mem_req_t req_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] mem_q [kmms_pkg::MEM_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
